FILE: rtl/idq_pkg.sv
// idq_pkg: shared types and constants for the indexed deque store
// operation and status codes, per-cell control struct, default sizes
// no dependencies
package idq_pkg;

	// default sizes
	localparam int DEPTH_DEF      = 32;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed field widths of the ports
	localparam int FUNC_W = 4;
	localparam int POS_W  = 6;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_BACK  = 4'd0,
		FN_PUSH_FRONT = 4'd1,
		FN_POP_BACK   = 4'd2,
		FN_POP_FRONT  = 4'd3,
		FN_READ       = 4'd4,
		FN_WRITE      = 4'd5,
		FN_INSERT     = 4'd6,
		FN_ERASE      = 4'd7,
		FN_CLEAR      = 4'd8
	} func_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// what each cell does with its element in one cycle
	typedef enum logic [1:0] {
		CA_HOLD,
		CA_WRITE,
		CA_INSERT,
		CA_REMOVE
	} cell_act_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		cell_act_t act;
		logic      rd_en;
		logic      back_en;
	} cell_ctl_t;

endpackage

FILE: rtl/idq_cell.sv
// idq_cell: one element slot of the deque chain
// holds one value, takes new data in place or from a neighbor on insert or remove
// depends on idq_pkg
module idq_cell import idq_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int CNT_W      = 6,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [CNT_W-1:0]      act_pos,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic [CNT_W-1:0]      rd_pos,
	input  logic [CNT_W-1:0]      back_pos,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] rd_data,
	output logic [DATA_WIDTH-1:0] back_data
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  at_pos;
	logic                  past_pos;

	assign at_pos   = (MY_IDX == act_pos);
	assign past_pos = (MY_IDX > act_pos);

	// element update: write in place, shift toward back, or shift toward front
	always_ff @(posedge clk) begin
		case (ctl.act)
			CA_WRITE: begin
				if (at_pos) data_q <= wr_data;
			end
			CA_INSERT: begin
				if (at_pos) data_q <= wr_data;
				else if (past_pos) data_q <= left_data;
			end
			CA_REMOVE: begin
				if (at_pos || past_pos) data_q <= right_data;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

	// gated taps for the read and back selection trees
	assign rd_data   = (ctl.rd_en && MY_IDX == rd_pos) ? data_q : '0;
	assign back_data = (ctl.back_en && MY_IDX == back_pos) ? data_q : '0;

endmodule

FILE: rtl/indexed_deque_store_core.sv
// indexed_deque_store_core: top level of the indexed deque store
// decode, element count, chain of idq_cell slots and result register
// depends on idq_pkg and idq_cell
//
// Double-ended queue of up to DEPTH signed values held in a chain of cells,
// one element per cell. Every operation (push or pop at either end, read or
// write at a position, insert before a position, erase, clear) is applied to
// all cells in the cycle its input beat is accepted: insert and erase shift
// every element past the position by one cell at once. The middle stage
// holds the beat; when it moves on, the value read, the front and the back
// element are selected from the cells and loaded into the output register.
// One operation is taken per cycle while the output side keeps up; a stalled
// output holds at most one more operation in the middle stage.
// Each input beat yields exactly one result beat. Full pushes and inserts,
// empty pops and erases, and positions past the contents are reported in
// status and change nothing.
module indexed_deque_store_core import idq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [FUNC_W-1:0]        func,
	input  logic [POS_W-1:0]         position,
	input  logic signed [VAL_W-1:0]  value_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [VAL_W-1:0]  value_out,
	output logic [POS_W-1:0]         result_position,
	output logic [POS_W-1:0]         count,
	output logic signed [VAL_W-1:0]  front_value,
	output logic signed [VAL_W-1:0]  back_value,
	output logic [STAT_W-1:0]        status
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int EXT_W = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	// handshake and stage control
	logic in_fire;
	logic s1_move;
	logic valid_s1;
	logic out_valid_q;

	// element count
	logic [CNT_W-1:0] count_q;

	// decode results
	cell_act_t        dec_act;
	logic [CNT_W-1:0] dec_pos;
	logic [CNT_W-1:0] dec_cnt;
	status_t          dec_stat;
	logic [POS_W-1:0] dec_rpos;
	logic             dec_rd;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic             is_full;
	logic             is_empty;

	// middle stage
	logic             rd_en_s1;
	logic [CNT_W-1:0] rd_pos_s1;
	logic [POS_W-1:0] rpos_s1;
	status_t          stat_s1;

	// cell chain wiring
	cell_ctl_t             ctl;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [EXT_W-1:0]      wr_ext;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
	logic [DATA_WIDTH-1:0] cell_back [DEPTH];
	logic [DATA_WIDTH-1:0] rd_sel;
	logic [DATA_WIDTH-1:0] back_sel;
	logic [CNT_W-1:0]      back_pos;
	logic [EXT_W-1:0]      rd_ext;
	logic [EXT_W-1:0]      back_ext;
	logic [EXT_W-1:0]      front_ext;
	logic [CMP_W-1:0]      cnt_out_x;

	// output register
	logic signed [VAL_W-1:0] value_out_q;
	logic [POS_W-1:0]        rpos_q;
	logic [POS_W-1:0]        count_out_q;
	logic signed [VAL_W-1:0] front_q;
	logic signed [VAL_W-1:0] back_q;
	logic [STAT_W-1:0]       status_q;

	assign s1_move  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_move;
	assign in_fire  = in_valid && in_ready;

	// operation decode against the current count
	assign pos_x    = CMP_W'(position);
	assign cnt_x    = CMP_W'(count_q);
	assign is_full  = (count_q == FULL_CNT);
	assign is_empty = (count_q == '0);

	always_comb begin
		dec_act  = CA_HOLD;
		dec_pos  = pos_x[CNT_W-1:0];
		dec_cnt  = count_q;
		dec_stat = ST_OK;
		dec_rpos = '0;
		dec_rd   = 1'b0;
		unique case (func)
			FN_PUSH_BACK: begin
				if (is_full) begin
					dec_stat = ST_FULL;
				end else begin
					dec_act = CA_WRITE;
					dec_pos = count_q;
					dec_cnt = count_q + 1'b1;
				end
			end
			FN_PUSH_FRONT: begin
				if (is_full) begin
					dec_stat = ST_FULL;
				end else begin
					dec_act = CA_INSERT;
					dec_pos = '0;
					dec_cnt = count_q + 1'b1;
				end
			end
			FN_POP_BACK: begin
				if (is_empty) dec_stat = ST_EMPTY;
				else dec_cnt = count_q - 1'b1;
			end
			FN_POP_FRONT: begin
				if (is_empty) begin
					dec_stat = ST_EMPTY;
				end else begin
					dec_act = CA_REMOVE;
					dec_pos = '0;
					dec_cnt = count_q - 1'b1;
				end
			end
			FN_READ: begin
				if (pos_x >= cnt_x) dec_stat = ST_RANGE;
				else dec_rd = 1'b1;
			end
			FN_WRITE: begin
				if (pos_x >= cnt_x) dec_stat = ST_RANGE;
				else dec_act = CA_WRITE;
			end
			FN_INSERT: begin
				if (pos_x > cnt_x) begin
					dec_stat = ST_RANGE;
				end else if (is_full) begin
					dec_stat = ST_FULL;
				end else begin
					dec_act  = CA_INSERT;
					dec_cnt  = count_q + 1'b1;
					dec_rpos = position;
				end
			end
			FN_ERASE: begin
				if (is_empty) begin
					dec_stat = ST_EMPTY;
					dec_rpos = position;
				end else if (pos_x >= cnt_x) begin
					dec_stat = ST_RANGE;
				end else begin
					dec_act  = CA_REMOVE;
					dec_cnt  = count_q - 1'b1;
					dec_rpos = position;
				end
			end
			FN_CLEAR: begin
				dec_cnt = '0;
			end
			default: begin
				dec_stat = ST_OK;
			end
		endcase
	end

	// count and stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) count_q <= dec_cnt;
			if (in_fire) valid_s1 <= 1'b1;
			else if (s1_move) valid_s1 <= 1'b0;
			if (valid_s1 && s1_move) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// middle stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_en_s1  <= dec_rd;
			rd_pos_s1 <= dec_pos;
			rpos_s1   <= dec_rpos;
			stat_s1   <= dec_stat;
		end
	end

	// broadcast to the chain; cells move only on an accepted beat
	assign wr_ext      = EXT_W'(value_in);
	assign wr_data     = wr_ext[DATA_WIDTH-1:0];
	assign ctl.act     = in_fire ? dec_act : CA_HOLD;
	assign ctl.rd_en   = rd_en_s1;
	assign ctl.back_en = !is_empty;
	assign back_pos    = count_q - 1'b1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		idq_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.act_pos    (dec_pos),
			.wr_data    (wr_data),
			.left_data  (left_d),
			.right_data (right_d),
			.rd_pos     (rd_pos_s1),
			.back_pos   (back_pos),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i]),
			.back_data  (cell_back[i])
		);
	end

	// or-combine the gated cell taps
	always_comb begin
		rd_sel   = '0;
		back_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_sel   = rd_sel | cell_rd[i];
			back_sel = back_sel | cell_back[i];
		end
	end

	// sign-extend stored values to the port width
	assign rd_ext    = EXT_W'($signed(rd_sel));
	assign back_ext  = EXT_W'($signed(back_sel));
	assign front_ext = is_empty ? '0 : EXT_W'($signed(cell_data[0]));
	assign cnt_out_x = CMP_W'(count_q);

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1 && s1_move) begin
			value_out_q <= rd_ext[VAL_W-1:0];
			rpos_q      <= rpos_s1;
			count_out_q <= cnt_out_x[POS_W-1:0];
			front_q     <= front_ext[VAL_W-1:0];
			back_q      <= back_ext[VAL_W-1:0];
			status_q    <= stat_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign value_out       = value_out_q;
	assign result_position = rpos_q;
	assign count           = count_out_q;
	assign front_value     = front_q;
	assign back_value      = back_q;
	assign status          = status_q;

endmodule

FILE: tb/sv/idq_checker.sv
// idq_checker: watches both channels of the indexed deque store, predicts each result beat
// and compares it field by field, counting mismatches for the testbench top
// depends on idq_pkg
module idq_checker import idq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [FUNC_W-1:0]       func,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value_in,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic signed [VAL_W-1:0] value_out,
	input  logic [POS_W-1:0]        result_position,
	input  logic [POS_W-1:0]        count,
	input  logic signed [VAL_W-1:0] front_value,
	input  logic signed [VAL_W-1:0] back_value,
	input  logic [STAT_W-1:0]       status,
	output int                      fail_count,
	output int                      pending,
	output int                      settled
);
	timeunit 1ns;
	timeprecision 1ps;

	// what one result beat should carry
	typedef struct {
		logic signed [VAL_W-1:0] rd_value;
		logic [POS_W-1:0]        pos;
		logic [POS_W-1:0]        size;
		logic signed [VAL_W-1:0] front;
		logic signed [VAL_W-1:0] back;
		status_t                 st;
	} deque_outcome_t;

	// shadow copy of the deque contents
	logic signed [VAL_W-1:0] held [DEPTH_DEF];
	int                      held_n = 0;

	deque_outcome_t outcome_q [$];
	int             accepted_ops = 0;
	int             taken_beats = 0;

	initial fail_count = 0;

	assign pending = accepted_ops - taken_beats;
	assign settled = taken_beats;

	// apply one operation to the shadow deque and describe the state after it
	function automatic deque_outcome_t apply_deque_op(logic [FUNC_W-1:0] fn,
			logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
		deque_outcome_t o;
		int p;
		o.rd_value = '0;
		o.pos = '0;
		o.st = ST_OK;
		p = int'(pos);
		case (fn)
			FN_PUSH_BACK: begin
				if (held_n >= DEPTH_DEF) begin
					o.st = ST_FULL;
				end else begin
					held[held_n] = val;
					held_n++;
				end
			end
			FN_PUSH_FRONT: begin
				if (held_n >= DEPTH_DEF) begin
					o.st = ST_FULL;
				end else begin
					for (int i = held_n; i > 0; i--)
						held[i] = held[i-1];
					held[0] = val;
					held_n++;
				end
			end
			FN_POP_BACK: begin
				if (held_n == 0)
					o.st = ST_EMPTY;
				else
					held_n--;
			end
			FN_POP_FRONT: begin
				if (held_n == 0) begin
					o.st = ST_EMPTY;
				end else begin
					for (int i = 0; i < held_n - 1; i++)
						held[i] = held[i+1];
					held_n--;
				end
			end
			FN_READ: begin
				if (p >= held_n)
					o.st = ST_RANGE;
				else
					o.rd_value = held[p];
			end
			FN_WRITE: begin
				if (p >= held_n)
					o.st = ST_RANGE;
				else
					held[p] = val;
			end
			FN_INSERT: begin
				// range check wins over the full check
				if (p > held_n) begin
					o.st = ST_RANGE;
				end else if (held_n >= DEPTH_DEF) begin
					o.st = ST_FULL;
				end else begin
					for (int i = held_n; i > p; i--)
						held[i] = held[i-1];
					held[p] = val;
					held_n++;
					o.pos = pos;
				end
			end
			FN_ERASE: begin
				// erase on an empty deque still echoes the position
				if (held_n == 0) begin
					o.st = ST_EMPTY;
					o.pos = pos;
				end else if (p >= held_n) begin
					o.st = ST_RANGE;
				end else begin
					for (int i = p; i < held_n - 1; i++)
						held[i] = held[i+1];
					held_n--;
					o.pos = pos;
				end
			end
			FN_CLEAR: held_n = 0;
			default: ;
		endcase
		o.size = held_n[POS_W-1:0];
		o.front = (held_n != 0) ? held[0] : '0;
		o.back = (held_n != 0) ? held[held_n-1] : '0;
		return o;
	endfunction

	// one line per mismatch
	task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
		fail_count++;
		$display("%0t mismatch on result beat %0d: %s got %h expected %h",
			$realtime, taken_beats, what, got, want);
	endtask

	// compare the output beat first, then record the input beat
	always @(posedge clk) begin
		deque_outcome_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("unexpected beat, status", VAL_W'(status), '0);
				end else begin
					want = outcome_q[0];
					outcome_q.delete(0);
					if (value_out !== want.rd_value)
						report_mismatch("value_out", value_out, want.rd_value);
					if (result_position !== want.pos)
						report_mismatch("result_position", VAL_W'(result_position),
							VAL_W'(want.pos));
					if (count !== want.size)
						report_mismatch("count", VAL_W'(count), VAL_W'(want.size));
					if (front_value !== want.front)
						report_mismatch("front_value", front_value, want.front);
					if (back_value !== want.back)
						report_mismatch("back_value", back_value, want.back);
					if (status !== want.st)
						report_mismatch("status", VAL_W'(status), VAL_W'(want.st));
					taken_beats <= taken_beats + 1;
				end
			end
			if (in_valid && in_ready) begin
				outcome_q.insert(outcome_q.size(), apply_deque_op(func, position, value_in));
				accepted_ops <= accepted_ops + 1;
			end
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: stimulus and verdict for indexed_deque_store_core
// drives directed and random deque operations with random idling on both sides
// depends on idq_pkg, indexed_deque_store_core and idq_checker
module tb_top;
	import idq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_OPS   = 1900;
	localparam int CALM_OPS     = 200;
	localparam int PAUSE_AT     = 950;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum int {
		MODE_GROW,
		MODE_SHRINK,
		MODE_ACCESS
	} op_mode_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [FUNC_W-1:0]       func;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value_in;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [VAL_W-1:0] value_out;
	logic [POS_W-1:0]        result_position;
	logic [POS_W-1:0]        count;
	logic signed [VAL_W-1:0] front_value;
	logic signed [VAL_W-1:0] back_value;
	logic [STAT_W-1:0]       status;

	int fail_count;
	int pending;
	int settled;
	bit calm = 1'b0;
	int fill_guess = 0;

	indexed_deque_store_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.position        (position),
		.value_in        (value_in),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.value_out       (value_out),
		.result_position (result_position),
		.count           (count),
		.front_value     (front_value),
		.back_value      (back_value),
		.status          (status)
	);

	idq_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.position        (position),
		.value_in        (value_in),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.value_out       (value_out),
		.result_position (result_position),
		.count           (count),
		.front_value     (front_value),
		.back_value      (back_value),
		.status          (status),
		.fail_count      (fail_count),
		.pending         (pending),
		.settled         (settled)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// result side: random stall bursts, one long hold-off, steady in the calm tail
	initial begin : result_taker
		bit held_off;
		held_off = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && settled >= HOLD_AFTER) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// offer one operation beat and hold it until accepted
	task automatic send_op(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
			logic signed [VAL_W-1:0] val);
		func <= fn;
		position <= pos;
		value_in <= val;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// rough fill level, only used to steer positions and modes
		case (fn)
			FN_PUSH_BACK, FN_PUSH_FRONT: if (fill_guess < DEPTH_DEF) fill_guess++;
			FN_POP_BACK, FN_POP_FRONT:   if (fill_guess > 0) fill_guess--;
			FN_INSERT: if (pos <= fill_guess && fill_guess < DEPTH_DEF) fill_guess++;
			FN_ERASE:  if (pos < fill_guess) fill_guess--;
			FN_CLEAR:  fill_guess = 0;
			default: ;
		endcase
	endtask

	// random sender idle burst
	task automatic sender_gap();
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(VAL_W-1){1'b0}}};
			1: return {1'b0, {(VAL_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// mostly inside the contents or at end, sometimes anywhere in the 6-bit field
	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return POS_W'($urandom_range(0, fill_guess));
		else if (r < 9)
			return POS_W'($urandom_range(0, DEPTH_DEF));
		else
			return POS_W'($urandom_range(0, (1 << POS_W) - 1));
	endfunction

	function automatic logic [FUNC_W-1:0] pick_op(op_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		if (r < 1)
			return FN_CLEAR;
		if (r < 2)
			return FUNC_W'($urandom_range(FN_CLEAR + 1, (1 << FUNC_W) - 1));
		case (mode)
			MODE_GROW: begin
				if (r < 30) return FN_PUSH_BACK;
				if (r < 55) return FN_PUSH_FRONT;
				if (r < 80) return FN_INSERT;
				if (r < 88) return FN_READ;
				if (r < 94) return FN_WRITE;
				if (r < 97) return FN_POP_BACK;
				return FN_ERASE;
			end
			MODE_SHRINK: begin
				if (r < 30) return FN_POP_BACK;
				if (r < 55) return FN_POP_FRONT;
				if (r < 85) return FN_ERASE;
				if (r < 92) return FN_READ;
				if (r < 96) return FN_WRITE;
				return FN_PUSH_BACK;
			end
			default: begin
				if (r < 30) return FN_READ;
				if (r < 60) return FN_WRITE;
				if (r < 70) return FN_INSERT;
				if (r < 80) return FN_ERASE;
				if (r < 85) return FN_PUSH_BACK;
				if (r < 90) return FN_POP_FRONT;
				if (r < 95) return FN_PUSH_FRONT;
				return FN_POP_BACK;
			end
		endcase
	endfunction

	// stimulus and verdict
	initial begin : stimulus
		op_mode_t mode;
		int       run_left;
		int       r;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FN_PUSH_BACK;
		position <= '0;
		value_in <= '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty no-ops, range checks, field extremes, every operation
		send_op(FN_POP_BACK, 6'd0, 0);                 sender_gap();
		send_op(FN_POP_FRONT, 6'd0, 0);                sender_gap();
		send_op(FN_ERASE, 6'd5, 0);                    sender_gap();
		send_op(FN_READ, 6'd0, 0);                     sender_gap();
		send_op(FN_WRITE, 6'd0, 32'sh1234_5678);       sender_gap();
		send_op(FN_INSERT, 6'd1, 32'sh1111_1111);      sender_gap();
		send_op(FN_INSERT, 6'd0, 32'sh8000_0000);      sender_gap();
		send_op(FN_PUSH_BACK, 6'd0, 32'sh7fff_ffff);   sender_gap();
		send_op(FN_PUSH_FRONT, 6'd0, -32'sd1);         sender_gap();
		send_op(FN_READ, 6'd1, 0);                     sender_gap();
		send_op(FN_WRITE, 6'd2, 0);                    sender_gap();
		send_op(FN_READ, 6'd3, 0);                     sender_gap();
		send_op(FN_INSERT, 6'd3, 32'sh5a5a_5a5a);      sender_gap();
		send_op(FN_INSERT, 6'd1, 32'sha5a5_a5a5);      sender_gap();
		send_op(FN_ERASE, 6'd0, 0);                    sender_gap();
		send_op(FN_ERASE, 6'd63, -32'sd1);             sender_gap();
		send_op(FN_WRITE, 6'd63, -32'sd1);             sender_gap();
		send_op(4'd15, 6'd63, -32'sd1);                sender_gap();
		send_op(FUNC_W'(FN_CLEAR + 1), 6'd0, 0);       sender_gap();
		send_op(FN_READ, 6'd0, 0);                     sender_gap();
		send_op(FN_POP_FRONT, 6'd0, 0);                sender_gap();
		send_op(FN_POP_BACK, 6'd0, 0);                 sender_gap();
		send_op(FN_CLEAR, 6'd0, 0);                    sender_gap();
		send_op(FN_READ, 6'd0, 0);                     sender_gap();
		send_op(FN_PUSH_FRONT, 6'd0, 1);               sender_gap();

		// random episodes that fill, drain or work on the contents
		mode = MODE_GROW;
		run_left = 60;
		for (int k = 0; k < RANDOM_OPS; k++) begin
			if (k == RANDOM_OPS - CALM_OPS)
				calm = 1'b1;
			if (k == PAUSE_AT) begin
				// let every outstanding result come back before going on
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (run_left == 0) begin
				r = $urandom_range(0, 99);
				if (fill_guess == DEPTH_DEF && r < 60)
					mode = MODE_SHRINK;
				else if (r < 45)
					mode = MODE_GROW;
				else if (r < 70)
					mode = MODE_SHRINK;
				else
					mode = MODE_ACCESS;
				run_left = $urandom_range(8, 80);
			end
			run_left--;
			send_op(pick_op(mode), pick_position(), pick_value());
			sender_gap();
		end

		// drain and verdict
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/idq_pkg.sv
rtl/idq_cell.sv
rtl/indexed_deque_store_core.sv
tb/sv/idq_checker.sv
tb/sv/tb_top.sv
